### rtl/dedup_window_median_filter_defines.svh
// Assertion macros shared by the checker of the window median filter.
// No dependencies; included by the checker file.
`ifndef DEDUP_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define DEDUP_WINDOW_MEDIAN_FILTER_DEFINES_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define DWMF_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at each rising clock edge outside reset.
`define DWMF_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/dwmf_pkg.sv
// Shared constants and types of the deduplicating window median filter.
// No dependencies; imported by the cell, the top level and the checker.
`default_nettype none
package dwmf_pkg;

	localparam int WINDOW_DEF = 5;
	localparam int COORD_W    = 16;
	localparam int TAG_W      = 32;

	// Request kinds carried in func
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_CLEAR  = 1'b1;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic wr;    // store the request sample in this cell
		logic load;  // copy stored values into the circulating registers
		logic rot;   // compare against circulating values, then shift
	} cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/dwmf_cell.sv
// One window entry: stored sample and tag, plus circulating copies used for ranking.
// Depends on dwmf_pkg.
`default_nettype none
module dwmf_cell import dwmf_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF,
	parameter int IDX    = 0
) (
	input  wire logic                          clk,
	input  wire cell_ctrl_t                    ctrl,
	input  wire logic [COORD_W-1:0]            wr_col,
	input  wire logic [COORD_W-1:0]            wr_row,
	input  wire logic [TAG_W-1:0]              wr_tag,
	input  wire logic [TAG_W-1:0]              chk_tag,
	input  wire logic [COORD_W-1:0]            circ_col_in,
	input  wire logic [COORD_W-1:0]            circ_row_in,
	input  wire logic [$clog2(WINDOW+1)-1:0]   circ_idx_in,
	output logic      [COORD_W-1:0]            circ_col_out,
	output logic      [COORD_W-1:0]            circ_row_out,
	output logic      [$clog2(WINDOW+1)-1:0]   circ_idx_out,
	output logic      [COORD_W-1:0]            own_col,
	output logic      [COORD_W-1:0]            own_row,
	output logic                               tag_eq,
	output logic      [$clog2(WINDOW+1)-1:0]   rank_col,
	output logic      [$clog2(WINDOW+1)-1:0]   rank_row
);

	localparam int IW = $clog2(WINDOW+1);
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [COORD_W-1:0] col_q, row_q, ccol_q, crow_q;
	logic [TAG_W-1:0]   tag_q;
	logic [IW-1:0]      cidx_q, rcol_q, rrow_q;
	logic               col_before, row_before;

	// Passing value ranks ahead of ours: smaller, or equal and from a lower slot
	always_comb begin
		col_before = (ccol_q < col_q) || ((ccol_q == col_q) && (cidx_q < MY_IDX));
		row_before = (crow_q < row_q) || ((crow_q == row_q) && (cidx_q < MY_IDX));
	end

	// Stored entry
	always_ff @(posedge clk) begin
		if (ctrl.wr) begin
			col_q <= wr_col;
			row_q <= wr_row;
			tag_q <= wr_tag;
		end
	end

	// Circulating copies and rank counters
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			ccol_q <= col_q;
			crow_q <= row_q;
			cidx_q <= MY_IDX;
			rcol_q <= '0;
			rrow_q <= '0;
		end else if (ctrl.rot) begin
			ccol_q <= circ_col_in;
			crow_q <= circ_row_in;
			cidx_q <= circ_idx_in;
			rcol_q <= rcol_q + IW'(col_before);
			rrow_q <= rrow_q + IW'(row_before);
		end
	end

	assign circ_col_out = ccol_q;
	assign circ_row_out = crow_q;
	assign circ_idx_out = cidx_q;
	assign own_col      = col_q;
	assign own_row      = row_q;
	assign tag_eq       = (tag_q == chk_tag);
	assign rank_col     = rcol_q;
	assign rank_row     = rrow_q;

endmodule
`default_nettype wire

### rtl/dedup_window_median_filter.sv
// Top level of the deduplicating window median filter: sequencer and cell ring.
// Depends on dwmf_pkg and dwmf_cell.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  request | in        | in_valid / in_ready  | func, col_sample, row_sample, frame_tag
//  result  | out       | out_valid / out_ready| ready_res, duplicate, median_col/row/valid
//
// A clear, a duplicate or a sample that leaves the window short of full goes from the check
// state straight to emit; a sample that leaves the window full passes through load, the
// WINDOW steps of values circulating around the cell ring, and select before emit, where
// the result register is loaded once the result channel is free.
// One request is worked at a time; a new one is taken while the last result waits.
// Reset clears fill count, write pointer, held medians and the valid mark.
// Window entries have no reset; only entries written since the last clear are read.
`default_nettype none
module dedup_window_median_filter import dwmf_pkg::*; #(
	parameter int WINDOW = WINDOW_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic [COORD_W-1:0] col_sample,
	input  wire logic [COORD_W-1:0] row_sample,
	input  wire logic [TAG_W-1:0]   frame_tag,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    ready_res,
	output logic                    duplicate,
	output logic      [COORD_W-1:0] median_col,
	output logic      [COORD_W-1:0] median_row,
	output logic                    median_valid
);

	localparam int IW = $clog2(WINDOW+1);
	localparam logic [IW-1:0] FULL    = IW'(WINDOW);
	localparam logic [IW-1:0] LAST_WP = IW'(WINDOW-1);
	localparam logic [IW-1:0] MID     = IW'(WINDOW/2);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_LOAD  = 3'd2;
	localparam logic [2:0] ST_ROT   = 3'd3;
	localparam logic [2:0] ST_SEL   = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [2:0]         state_q;
	logic               req_func_q;
	logic [COORD_W-1:0] req_col_q, req_row_q;
	logic [TAG_W-1:0]   req_tag_q;
	logic [IW-1:0]      fill_q, wp_q, rot_q;
	logic               fresh_q, dup_q;
	logic [COORD_W-1:0] held_col_q, held_row_q;
	logic               valid_mark_q;
	logic               out_valid_q, out_fresh_q, out_dup_q, out_mv_q;
	logic [COORD_W-1:0] out_col_q, out_row_q;

	logic [WINDOW-1:0]  tag_eq, hit_vec;
	logic               dup_hit;
	logic [IW-1:0]      fill_inc;
	logic [COORD_W-1:0] sel_col, sel_row;
	logic               out_free;

	cell_ctrl_t         ctrl   [WINDOW];
	logic [COORD_W-1:0] ccol   [WINDOW];
	logic [COORD_W-1:0] crow   [WINDOW];
	logic [IW-1:0]      cidx   [WINDOW];
	logic [COORD_W-1:0] ocol   [WINDOW];
	logic [COORD_W-1:0] orow   [WINDOW];
	logic [IW-1:0]      rkcol  [WINDOW];
	logic [IW-1:0]      rkrow  [WINDOW];

	// Cell ring: each cell passes its circulating values to the previous slot
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		always_comb begin
			ctrl[i].wr   = (state_q == ST_CHECK) && (req_func_q == FUNC_SAMPLE)
				&& !dup_hit && (wp_q == IW'(i));
			ctrl[i].load = (state_q == ST_LOAD);
			ctrl[i].rot  = (state_q == ST_ROT);
		end

		dwmf_cell #(.WINDOW(WINDOW), .IDX(i)) u_cell (
			.clk          (clk),
			.ctrl         (ctrl[i]),
			.wr_col       (req_col_q),
			.wr_row       (req_row_q),
			.wr_tag       (req_tag_q),
			.chk_tag      (req_tag_q),
			.circ_col_in  (ccol[(i+1)%WINDOW]),
			.circ_row_in  (crow[(i+1)%WINDOW]),
			.circ_idx_in  (cidx[(i+1)%WINDOW]),
			.circ_col_out (ccol[i]),
			.circ_row_out (crow[i]),
			.circ_idx_out (cidx[i]),
			.own_col      (ocol[i]),
			.own_row      (orow[i]),
			.tag_eq       (tag_eq[i]),
			.rank_col     (rkcol[i]),
			.rank_row     (rkrow[i])
		);

		// Only entries written since the last clear take part in the tag scan
		assign hit_vec[i] = tag_eq[i] && (IW'(i) < fill_q);
	end

	assign dup_hit  = |hit_vec;
	assign fill_inc = (fill_q < FULL) ? fill_q + IW'(1) : fill_q;
	assign out_free = !out_valid_q || out_ready;

	// Median pick: exactly one cell holds the middle rank
	always_comb begin
		sel_col = '0;
		sel_row = '0;
		for (int k = 0; k < WINDOW; k++) begin
			if (rkcol[k] == MID) sel_col = sel_col | ocol[k];
			if (rkrow[k] == MID) sel_row = sel_row | orow[k];
		end
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_func_q <= func;
			req_col_q  <= col_sample;
			req_row_q  <= row_sample;
			req_tag_q  <= frame_tag;
		end
	end

	// Sequencer and window bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			fill_q       <= '0;
			wp_q         <= '0;
			rot_q        <= '0;
			fresh_q      <= 1'b0;
			dup_q        <= 1'b0;
			held_col_q   <= '0;
			held_row_q   <= '0;
			valid_mark_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					fresh_q <= 1'b0;
					dup_q   <= 1'b0;
					state_q <= ST_EMIT;
					if (req_func_q == FUNC_CLEAR) begin
						fill_q       <= '0;
						wp_q         <= '0;
						valid_mark_q <= 1'b0;
					end else if (dup_hit) begin
						dup_q <= 1'b1;
					end else begin
						wp_q   <= (wp_q >= LAST_WP) ? '0 : wp_q + IW'(1);
						fill_q <= fill_inc;
						if (fill_inc >= FULL) begin
							fresh_q <= 1'b1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					rot_q   <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					rot_q <= rot_q + IW'(1);
					if (rot_q == LAST_WP) state_q <= ST_SEL;
				end
				ST_SEL: begin
					held_col_q   <= sel_col;
					held_row_q   <= sel_row;
					valid_mark_q <= 1'b1;
					state_q      <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			out_fresh_q <= fresh_q;
			out_dup_q   <= dup_q;
			out_col_q   <= held_col_q;
			out_row_q   <= held_row_q;
			out_mv_q    <= valid_mark_q;
		end
	end

	assign in_ready     = (state_q == ST_IDLE);
	assign out_valid    = out_valid_q;
	assign ready_res    = out_fresh_q;
	assign duplicate    = out_dup_q;
	assign median_col   = out_col_q;
	assign median_row   = out_row_q;
	assign median_valid = out_mv_q;

endmodule
`default_nettype wire

### rtl/dwmf_chk.sv
// Port-level checker for the window median filter, bound to the top level.
// Depends on dedup_window_median_filter_defines.svh and dwmf_pkg.
`default_nettype none
`include "dedup_window_median_filter_defines.svh"
module dwmf_chk import dwmf_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic               ready_res,
	input wire logic               duplicate,
	input wire logic [COORD_W-1:0] median_col,
	input wire logic [COORD_W-1:0] median_row,
	input wire logic               median_valid
);

	// A stalled result holds its payload
	`DWMF_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(median_col) && $stable(median_row) && $stable(ready_res), "result changed while stalled")

	// A fresh median always carries the valid mark
	`DWMF_ASSERT_IMP(a_fresh_valid, clk, arst_n, out_valid && ready_res, median_valid, "fresh median without valid mark")

	// A dropped sample never yields a fresh median
	`DWMF_ASSERT_IMP(a_dup_excl, clk, arst_n, out_valid && duplicate, !ready_res, "duplicate and fresh median together")

endmodule

bind dedup_window_median_filter dwmf_chk u_dwmf_chk (.*);
`default_nettype wire
